// ===== hdl/calu_pkg.sv =====
// shared types and constants of the 8-bit cpu execute stage
`timescale 1ns / 1ps
`default_nettype none

package calu_pkg;

    localparam int unsigned MODE_W = 6;
    localparam int unsigned DATA_W = 8;

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [DATA_W-1:0] t_byte;

    // operation codes
    localparam t_mode MODE_ADC   = 6'd0;
    localparam t_mode MODE_SBC   = 6'd1;
    localparam t_mode MODE_AND   = 6'd2;
    localparam t_mode MODE_ORA   = 6'd3;
    localparam t_mode MODE_EOR   = 6'd4;
    localparam t_mode MODE_CMP   = 6'd5;
    localparam t_mode MODE_CPX   = 6'd6;
    localparam t_mode MODE_CPY   = 6'd7;
    localparam t_mode MODE_BIT   = 6'd8;
    localparam t_mode MODE_LDA   = 6'd9;
    localparam t_mode MODE_LDX   = 6'd10;
    localparam t_mode MODE_LDY   = 6'd11;
    localparam t_mode MODE_INC   = 6'd12;
    localparam t_mode MODE_DEC   = 6'd13;
    localparam t_mode MODE_INX   = 6'd14;
    localparam t_mode MODE_INY   = 6'd15;
    localparam t_mode MODE_DEX   = 6'd16;
    localparam t_mode MODE_DEY   = 6'd17;
    localparam t_mode MODE_ASL_A = 6'd18;
    localparam t_mode MODE_LSR_A = 6'd19;
    localparam t_mode MODE_ROL_A = 6'd20;
    localparam t_mode MODE_ROR_A = 6'd21;
    localparam t_mode MODE_ASL_M = 6'd22;
    localparam t_mode MODE_LSR_M = 6'd23;
    localparam t_mode MODE_ROL_M = 6'd24;
    localparam t_mode MODE_ROR_M = 6'd25;
    localparam t_mode MODE_TAX   = 6'd26;
    localparam t_mode MODE_TAY   = 6'd27;
    localparam t_mode MODE_TXA   = 6'd28;
    localparam t_mode MODE_TYA   = 6'd29;
    localparam t_mode MODE_TSX   = 6'd30;
    localparam t_mode MODE_TXS   = 6'd31;
    localparam t_mode MODE_CLC   = 6'd32;
    localparam t_mode MODE_SEC   = 6'd33;
    localparam t_mode MODE_CLI   = 6'd34;
    localparam t_mode MODE_SEI   = 6'd35;
    localparam t_mode MODE_CLV   = 6'd36;
    localparam t_mode MODE_CLD   = 6'd37;
    localparam t_mode MODE_SED   = 6'd38;

    // shift kinds
    localparam logic [1:0] SHIFT_ASL = 2'd0;
    localparam logic [1:0] SHIFT_LSR = 2'd1;
    localparam logic [1:0] SHIFT_ROL = 2'd2;
    localparam logic [1:0] SHIFT_ROR = 2'd3;

    // status bit positions
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_B = 4;
    localparam int unsigned FLAG_U = 5;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    localparam t_byte SP_RESET     = 8'hFD;
    localparam t_byte STATUS_RESET = 8'h20;

    typedef struct packed {
        t_byte a;
        t_byte x;
        t_byte y;
        t_byte sp;
        t_byte p;
    } t_regs;

    typedef struct packed {
        t_byte result;
        logic  wr;
        t_regs regs;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/calu_exec.sv =====
// combinational execute logic: one operation on the register set
`timescale 1ns / 1ps
`default_nettype none

module calu_exec (
    input  wire calu_pkg::t_mode   i_mode,
    input  wire calu_pkg::t_byte   i_operand,
    input  wire calu_pkg::t_regs   i_cur,
    output calu_pkg::t_result      o_res
);
    import calu_pkg::*;

    function automatic t_byte zn(input t_byte p, input t_byte v);
        t_byte q;
        q = p;
        q[FLAG_Z] = (v == '0);
        q[FLAG_N] = v[7];
        return q;
    endfunction

    t_byte       addend;
    logic [8:0]  sum;
    t_byte       cmp_reg;
    logic [8:0]  cmp_diff;
    t_byte       sh_src;
    logic [1:0]  sh_kind;
    t_byte       sh_val;
    logic        sh_c;
    logic        cin;
    t_regs       n;
    t_byte       res;
    logic        wr;

    assign cin = i_cur.p[FLAG_C];

    assign addend = (i_mode == MODE_SBC) ? ~i_operand : i_operand;
    assign sum    = {1'b0, i_cur.a} + {1'b0, addend} + {8'd0, cin};

    always_comb begin
        case (i_mode)
            MODE_CPX: cmp_reg = i_cur.x;
            MODE_CPY: cmp_reg = i_cur.y;
            default:  cmp_reg = i_cur.a;
        endcase
    end
    assign cmp_diff = {1'b0, cmp_reg} + {1'b0, ~i_operand} + 9'd1;

    // both shift groups start at a code whose low bits are two
    assign sh_kind = i_mode[1:0] + 2'd2;
    assign sh_src  = (i_mode >= MODE_ASL_M) ? i_operand : i_cur.a;

    always_comb begin
        case (sh_kind)
            SHIFT_ASL: begin
                sh_c   = sh_src[7];
                sh_val = {sh_src[6:0], 1'b0};
            end
            SHIFT_LSR: begin
                sh_c   = sh_src[0];
                sh_val = {1'b0, sh_src[7:1]};
            end
            SHIFT_ROL: begin
                sh_c   = sh_src[7];
                sh_val = {sh_src[6:0], cin};
            end
            default: begin
                sh_c   = sh_src[0];
                sh_val = {cin, sh_src[7:1]};
            end
        endcase
    end

    always_comb begin
        n   = i_cur;
        res = '0;
        wr  = 1'b0;
        unique case (i_mode) inside
            MODE_ADC, MODE_SBC: begin
                n.a = sum[7:0];
                n.p = zn(i_cur.p, sum[7:0]);
                n.p[FLAG_C] = sum[8];
                n.p[FLAG_V] = ~(i_cur.a[7] ^ addend[7]) & (i_cur.a[7] ^ sum[7]);
            end
            MODE_AND: begin
                n.a = i_cur.a & i_operand;
                n.p = zn(i_cur.p, i_cur.a & i_operand);
            end
            MODE_ORA: begin
                n.a = i_cur.a | i_operand;
                n.p = zn(i_cur.p, i_cur.a | i_operand);
            end
            MODE_EOR: begin
                n.a = i_cur.a ^ i_operand;
                n.p = zn(i_cur.p, i_cur.a ^ i_operand);
            end
            MODE_CMP, MODE_CPX, MODE_CPY: begin
                n.p[FLAG_C] = cmp_diff[8];
                n.p[FLAG_Z] = (cmp_reg == i_operand);
                n.p[FLAG_N] = cmp_diff[7];
            end
            MODE_BIT: begin
                n.p[FLAG_Z] = ((i_cur.a & i_operand) == '0);
                n.p[FLAG_N] = i_operand[7];
                n.p[FLAG_V] = i_operand[6];
            end
            MODE_LDA: begin
                n.a = i_operand;
                n.p = zn(i_cur.p, i_operand);
            end
            MODE_LDX: begin
                n.x = i_operand;
                n.p = zn(i_cur.p, i_operand);
            end
            MODE_LDY: begin
                n.y = i_operand;
                n.p = zn(i_cur.p, i_operand);
            end
            MODE_INC: begin
                res = i_operand + 8'd1;
                wr  = 1'b1;
                n.p = zn(i_cur.p, i_operand + 8'd1);
            end
            MODE_DEC: begin
                res = i_operand - 8'd1;
                wr  = 1'b1;
                n.p = zn(i_cur.p, i_operand - 8'd1);
            end
            MODE_INX: begin
                n.x = i_cur.x + 8'd1;
                n.p = zn(i_cur.p, i_cur.x + 8'd1);
            end
            MODE_INY: begin
                n.y = i_cur.y + 8'd1;
                n.p = zn(i_cur.p, i_cur.y + 8'd1);
            end
            MODE_DEX: begin
                n.x = i_cur.x - 8'd1;
                n.p = zn(i_cur.p, i_cur.x - 8'd1);
            end
            MODE_DEY: begin
                n.y = i_cur.y - 8'd1;
                n.p = zn(i_cur.p, i_cur.y - 8'd1);
            end
            MODE_ASL_A, MODE_LSR_A, MODE_ROL_A, MODE_ROR_A: begin
                n.a = sh_val;
                n.p = zn(i_cur.p, sh_val);
                n.p[FLAG_C] = sh_c;
            end
            MODE_ASL_M, MODE_LSR_M, MODE_ROL_M, MODE_ROR_M: begin
                res = sh_val;
                wr  = 1'b1;
                n.p = zn(i_cur.p, sh_val);
                n.p[FLAG_C] = sh_c;
            end
            MODE_TAX: begin
                n.x = i_cur.a;
                n.p = zn(i_cur.p, i_cur.a);
            end
            MODE_TAY: begin
                n.y = i_cur.a;
                n.p = zn(i_cur.p, i_cur.a);
            end
            MODE_TXA: begin
                n.a = i_cur.x;
                n.p = zn(i_cur.p, i_cur.x);
            end
            MODE_TYA: begin
                n.a = i_cur.y;
                n.p = zn(i_cur.p, i_cur.y);
            end
            MODE_TSX: begin
                n.x = i_cur.sp;
                n.p = zn(i_cur.p, i_cur.sp);
            end
            MODE_TXS: n.sp = i_cur.x;
            MODE_CLC: n.p[FLAG_C] = 1'b0;
            MODE_SEC: n.p[FLAG_C] = 1'b1;
            MODE_CLI: n.p[FLAG_I] = 1'b0;
            MODE_SEI: n.p[FLAG_I] = 1'b1;
            MODE_CLV: n.p[FLAG_V] = 1'b0;
            MODE_CLD: n.p[FLAG_D] = 1'b0;
            MODE_SED: n.p[FLAG_D] = 1'b1;
            default: begin
                // unused codes leave everything unchanged
            end
        endcase
    end

    assign o_res.result = res;
    assign o_res.wr     = wr;
    assign o_res.regs   = n;

endmodule

`default_nettype wire

// ===== hdl/cpu_alu_register_file_8bit_unit.sv =====
// top level of the 8-bit cpu execute stage: input register, execute, result register
// path: an accepted item passes the input register, then the result register, unless stalled
// throughput: one item per cycle while the output is not stalled; the execute logic is combinational
// a stalled output holds its item and one more item can wait in the input register
// reset: synchronous active low; A, X, Y cleared, stack pointer 0xFD, status 0x20
// reset empties both stages; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module cpu_alu_register_file_8bit_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire calu_pkg::t_mode i_mode,
    input  wire calu_pkg::t_byte i_operand,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output calu_pkg::t_byte     o_result_byte,
    output logic                o_memory_write,
    output calu_pkg::t_byte     o_status_value,
    output calu_pkg::t_byte     o_accumulator_value,
    output calu_pkg::t_byte     o_index_x_value,
    output calu_pkg::t_byte     o_index_y_value,
    output calu_pkg::t_byte     o_stack_pointer_value
);
    import calu_pkg::*;

    logic    r_in_valid;
    t_mode   r_mode;
    t_byte   r_operand;
    t_regs   r_regs;
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    logic    advance;

    calu_exec u_exec (
        .i_mode    (r_mode),
        .i_operand (r_operand),
        .i_cur     (r_regs),
        .o_res     (n_out)
    );

    // the input stage moves on when the result register is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_regs.a    <= '0;
            r_regs.x    <= '0;
            r_regs.y    <= '0;
            r_regs.sp   <= SP_RESET;
            r_regs.p    <= STATUS_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_regs      <= n_out.regs;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode    <= i_mode;
            r_operand <= i_operand;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_result_byte         = r_out.result;
    assign o_memory_write        = r_out.wr;
    assign o_status_value        = r_out.regs.p;
    assign o_accumulator_value   = r_out.regs.a;
    assign o_index_x_value       = r_out.regs.x;
    assign o_index_y_value       = r_out.regs.y;
    assign o_stack_pointer_value = r_out.regs.sp;

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register not filled after transfer from input stage");

    a_state_only_on_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_regs))
        else $error("register set changed without an item");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |=> (r_in_valid && $stable(r_mode)))
        else $error("waiting item lost from input stage");

    a_fixed_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_regs.p[FLAG_U] && !r_regs.p[FLAG_B])
        else $error("status bits B or U changed");

    a_write_only_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_memory_write) |-> (o_result_byte == '0))
        else $error("result byte nonzero without memory write");

endmodule

`default_nettype wire
